### hdl/uirf_pkg.sv
// shared constants and types of the uart receive framer
`timescale 1ns / 1ps

package uirf_pkg;

  // ring depth default and field widths
  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned TIMER_W        = 8;

  // idle timeout after reset, in ticks
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 8'd3;

  // input item kind
  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

endpackage

### hdl/uirf_in_if.sv
// input channel of the framer: received bytes and timer ticks
`timescale 1ns / 1ps

interface uirf_in_if;
  logic                             valid;
  logic                             ready;
  uirf_pkg::func_e                  func;
  logic [uirf_pkg::BYTE_W-1:0]      rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

### hdl/uirf_out_if.sv
// output channel of the framer: released frame bytes
`timescale 1ns / 1ps

interface uirf_out_if;
  logic                             valid;
  logic                             ready;
  logic [uirf_pkg::BYTE_W-1:0]      out_byte;
  logic                             frame_end;
  logic                             frame_empty;

  modport source (output valid, output out_byte, output frame_end, output frame_empty,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input frame_empty,
                  output ready);
endinterface

### hdl/uart_rx_idle_timeout_framer.sv
// uart receive framer: byte ring with idle timeout release
`timescale 1ns / 1ps

// Collects received bytes in a ring memory of RingDepth entries and releases
// them as one frame once idle_timeout ticks pass with no new byte. A byte or
// a tick transaction is taken while the framer is idle. On expiry the held
// bytes are read from the ring memory one per cycle while the output does
// not stall, through a registered read and then the output register, and
// the input is held off until the walk ends; an expiry with nothing held
// gives one empty-frame result. Results sit in an output register, so a
// byte may be taken while the last result of a frame still waits. Filling
// the ring discards everything held. The ring needs no clearing after reset.
module uart_rx_idle_timeout_framer #(
  parameter int unsigned RingDepth = uirf_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  uirf_in_if.sink                      in_i,
  uirf_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [uirf_pkg::TIMER_W-1:0] cfg_data_i
);

  localparam int unsigned PosW = $clog2(RingDepth);
  localparam logic [PosW-1:0] LastPos = PosW'(RingDepth - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] pos);
    return (pos == LastPos) ? '0 : pos + 1'b1;
  endfunction

  logic [1:0]                    state_q, state_d;
  logic [PosW-1:0]               wr_pos_q, wr_pos_d;
  logic [PosW-1:0]               rd_pos_q, rd_pos_d;
  logic [PosW-1:0]               held_q, held_d;
  logic [uirf_pkg::TIMER_W-1:0]  timer_q, timer_d;
  logic                          armed_q, armed_d;
  logic [uirf_pkg::TIMER_W-1:0]  timeout_q;
  logic                          inflight_q, inflight_d;
  logic                          inflight_last_q, inflight_last_d;

  logic                          out_valid_q, out_valid_d;
  logic [uirf_pkg::BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic                          out_end_q, out_end_d;
  logic                          out_empty_q, out_empty_d;

  logic [uirf_pkg::BYTE_W-1:0]   ring_mem [RingDepth];
  logic [uirf_pkg::BYTE_W-1:0]   rd_data_q;
  logic                          wr_en;
  logic                          rd_en;

  logic in_fire, byte_fire, tick_fire;
  logic can_load, load_byte, load_empty;
  logic [PosW-1:0] wr_pos_inc;

  // input handshake decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign byte_fire  = in_fire && (in_i.func == uirf_pkg::FUNC_BYTE);
  assign tick_fire  = in_fire && (in_i.func == uirf_pkg::FUNC_TICK);
  assign wr_pos_inc = next_pos(wr_pos_q);

  // output register may take a new result
  assign can_load   = !out_valid_q || out_o.ready;
  assign load_byte  = inflight_q && can_load;
  assign load_empty = (state_q == ST_EMPTY) && can_load;

  // read issue while draining, one ahead of the output register
  assign rd_en = (state_q == ST_DRAIN) && (held_q != '0) && (!inflight_q || load_byte);
  assign wr_en = byte_fire;

  // ring memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_pos_q] <= in_i.rx_byte;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_pos_q];
    end
  end

  // sequencer and ring bookkeeping
  always_comb begin
    state_d         = state_q;
    wr_pos_d        = wr_pos_q;
    rd_pos_d        = rd_pos_q;
    held_d          = held_q;
    timer_d         = timer_q;
    armed_d         = armed_q;
    inflight_d      = inflight_q;
    inflight_last_d = inflight_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (byte_fire) begin
          if (wr_pos_inc == rd_pos_q) begin
            wr_pos_d = '0;
            rd_pos_d = '0;
            held_d   = '0;
          end else begin
            wr_pos_d = wr_pos_inc;
            held_d   = held_q + 1'b1;
          end
          timer_d = timeout_q;
          armed_d = 1'b1;
        end else if (tick_fire && armed_q) begin
          if (timer_q > uirf_pkg::TIMER_W'(1)) begin
            timer_d = timer_q - 1'b1;
          end else begin
            timer_d = '0;
            armed_d = 1'b0;
            state_d = (held_q == '0) ? ST_EMPTY : ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_en) begin
          rd_pos_d        = next_pos(rd_pos_q);
          held_d          = held_q - 1'b1;
          inflight_d      = 1'b1;
          inflight_last_d = (held_q == PosW'(1));
        end else if (load_byte) begin
          inflight_d = 1'b0;
        end
        if ((held_q == '0) && !inflight_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_empty_d = out_empty_q;
    if (load_byte) begin
      out_valid_d = 1'b1;
      out_byte_d  = rd_data_q;
      out_end_d   = inflight_last_q;
      out_empty_d = 1'b0;
    end else if (load_empty) begin
      out_valid_d = 1'b1;
      out_byte_d  = '0;
      out_end_d   = 1'b1;
      out_empty_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      wr_pos_q        <= '0;
      rd_pos_q        <= '0;
      held_q          <= '0;
      timer_q         <= '0;
      armed_q         <= 1'b0;
      timeout_q       <= uirf_pkg::TIMEOUT_RESET;
      inflight_q      <= 1'b0;
      inflight_last_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      wr_pos_q        <= wr_pos_d;
      rd_pos_q        <= rd_pos_d;
      held_q          <= held_d;
      timer_q         <= timer_d;
      armed_q         <= armed_d;
      inflight_q      <= inflight_d;
      inflight_last_q <= inflight_last_d;
      out_valid_q     <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // output payload registers
  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_end_q   <= out_end_d;
    out_empty_q <= out_empty_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.frame_end   = out_end_q;
  assign out_o.frame_empty = out_empty_q;

endmodule

### hdl/uirf_chk.sv
// port-level assertions of the framer and their bind
`timescale 1ns / 1ps

module uirf_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input uirf_pkg::func_e             in_func_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [uirf_pkg::BYTE_W-1:0] out_byte_i,
  input logic                        out_end_i,
  input logic                        out_empty_i
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_end_i) && $stable(out_empty_i))
    else $error("stalled result changed");

  // an empty frame is a single closing result with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_end_i && (out_byte_i == '0))
    else $error("empty frame result malformed");

  // no input transaction while a frame is still being released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_end_i |-> !in_ready_i)
    else $error("input taken in the middle of a frame");

  // a byte transaction never starts a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == uirf_pkg::FUNC_BYTE) |=> !$rose(out_valid_i))
    else $error("result raised by a received byte");

endmodule

bind uart_rx_idle_timeout_framer uirf_chk u_uirf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_end_i   (out_o.frame_end),
  .out_empty_i (out_o.frame_empty)
);

### sim/tb_top.sv
// self-checking testbench of the uart receive framer with idle timeout release
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RING          = uirf_pkg::RING_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES  = RING + 8;
  localparam int unsigned PLAN_ROWS     = 26;
  localparam int unsigned RAND_ITEMS    = 25;
  localparam int unsigned MIN_PHASES    = 3;
  localparam int unsigned SEQ_PER_PHASE = 2;
  localparam int unsigned MAX_PRINTS    = 20;

  typedef struct packed {
    logic [uirf_pkg::BYTE_W-1:0] out_byte;
    logic                        frame_end;
    logic                        frame_empty;
  } frame_res_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG,
    ROW_FILL
  } row_kind_e;

  // one line of the directed table; data is the byte, the timeout or the fill length
  typedef struct packed {
    row_kind_e         kind;
    uirf_pkg::func_e   func;
    logic [7:0]        data;
    logic              typed;
    frame_res_t        want;
  } step_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [uirf_pkg::TIMER_W-1:0]  cfg_data_i;

  uirf_in_if  in_if ();
  uirf_out_if out_if ();

  uart_rx_idle_timeout_framer #(
    .RingDepth (RING)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock generation
  always #4 clk_i = ~clk_i;

  // framer model state
  logic [uirf_pkg::BYTE_W-1:0]  ring_m [RING];
  int unsigned                  wr_pos;
  int unsigned                  rd_pos;
  int unsigned                  held_cnt;
  int unsigned                  silence_cnt;
  bit                           timer_on;
  logic [uirf_pkg::TIMER_W-1:0] idle_ticks;

  // frame bytes still owed by the framer, oldest first
  frame_res_t         frame_due_q [$];

  // run statistics
  int unsigned        mismatch_cnt;
  int unsigned        checked_cnt;
  int unsigned        byte_cnt;
  int unsigned        tick_cnt;
  int unsigned        frame_cnt;
  int unsigned        empty_cnt;
  int unsigned        live_items;
  int unsigned        cfg_writes;
  bit                 calm;

  step_row_t          plan [PLAN_ROWS];

  // mismatch reporting, printout capped but every failure counted
  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  // framer prediction for one accepted transaction
  task automatic framer_step(input uirf_pkg::func_e f, input logic [uirf_pkg::BYTE_W-1:0] b,
                             output bit live);
    live = 1'b1;
    if (f == uirf_pkg::FUNC_BYTE) begin
      ring_m[wr_pos] = b;
      held_cnt++;
      wr_pos = (wr_pos + 1) % RING;
      // ring full: everything held is thrown away
      if (wr_pos == rd_pos) begin
        wr_pos   = 0;
        rd_pos   = 0;
        held_cnt = 0;
      end
      silence_cnt = 32'(idle_ticks);
      timer_on    = 1'b1;
      byte_cnt++;
    end else if (!timer_on) begin
      live = 1'b0;
    end else if (silence_cnt > 1) begin
      silence_cnt--;
      tick_cnt++;
    end else begin
      // expiry: release the frame, or one empty marker
      silence_cnt = 0;
      timer_on    = 1'b0;
      tick_cnt++;
      if (held_cnt == 0) begin
        frame_due_q.push_back(frame_res_t'{out_byte: '0, frame_end: 1'b1, frame_empty: 1'b1});
        empty_cnt++;
      end else begin
        for (int unsigned k = 0; k < held_cnt; k++) begin
          frame_due_q.push_back(frame_res_t'{out_byte: ring_m[rd_pos],
                                             frame_end: (k + 1 == held_cnt),
                                             frame_empty: 1'b0});
          rd_pos = (rd_pos + 1) % RING;
        end
        held_cnt = 0;
        frame_cnt++;
      end
    end
  endtask

  // drive one transaction, predict at acceptance, then maybe idle
  task automatic send_item(input uirf_pkg::func_e f, input logic [uirf_pkg::BYTE_W-1:0] b,
                           input logic typed, input frame_res_t want);
    int unsigned q_mark;
    int unsigned gap;
    bit          live;
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.rx_byte <= b;
    do begin
      @(posedge clk_i);
    end while (in_if.ready !== 1'b1);
    q_mark = frame_due_q.size();
    framer_step(f, b, live);
    // hand-written expectation takes the place of the predicted one
    if (typed) begin
      while (frame_due_q.size() > q_mark) begin
        void'(frame_due_q.pop_back());
      end
      frame_due_q.push_back(want);
    end
    if (live) begin
      live_items++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_bytes(input int unsigned n);
    repeat (n) begin
      send_item(uirf_pkg::FUNC_BYTE, uirf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) begin
      send_item(uirf_pkg::FUNC_TICK, uirf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  // wait until the framer owes nothing and has finished any frame walk
  task automatic settle();
    in_if.valid <= 1'b0;
    while (frame_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // idle timeout register write, only once the framer is quiet
  task automatic write_timeout(input logic [uirf_pkg::TIMER_W-1:0] v);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    idle_ticks = v;
    cfg_writes++;
    cfg_we_i   <= 1'b0;
  endtask

  // output side: random back-pressure
  int unsigned sink_hold = 0;
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      out_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_if.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        sink_hold = pick_gap();
      end
    end
  end

  // result checking against the oldest owed frame byte
  always @(posedge clk_i) begin : res_check
    frame_res_t got;
    frame_res_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_byte: out_if.out_byte, frame_end: out_if.frame_end,
              frame_empty: out_if.frame_empty};
      checked_cnt++;
      if (frame_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h end=%b empty=%b",
                                  got.out_byte, got.frame_end, got.frame_empty));
      end else begin
        want = frame_due_q.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("got byte=%02h end=%b empty=%b, want byte=%02h end=%b empty=%b",
                                    got.out_byte, got.frame_end, got.frame_empty,
                                    want.out_byte, want.frame_end, want.frame_empty));
        end
      end
    end
  end

  // run limit
  initial begin
    #50_000_000;
    $display("timeout, %0d results still owed", frame_due_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned rand_base;
    int unsigned eff_to;
    int unsigned r;
    int unsigned k;

    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.func    <= uirf_pkg::FUNC_TICK;
    in_if.rx_byte <= '0;
    cfg_we_i      <= 1'b0;
    cfg_data_i    <= '0;
    calm          = 1'b0;
    wr_pos        = 0;
    rd_pos        = 0;
    held_cnt      = 0;
    silence_cnt   = 0;
    timer_on      = 1'b0;
    idle_ticks    = uirf_pkg::TIMEOUT_RESET;
    foreach (ring_m[i]) ring_m[i] = '0;

    // directed table
    plan = '{
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b0, '0},     // tick before any byte
      '{ROW_ITEM, uirf_pkg::FUNC_BYTE, 8'h00, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}}, // reset timeout
      '{ROW_ITEM, uirf_pkg::FUNC_BYTE, 8'hFF, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_BYTE, 8'hA5, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'hFF, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'hFF, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'hFF, 1'b0, '0},
      '{ROW_CFG,  uirf_pkg::FUNC_TICK, 8'd1,  1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_BYTE, 8'h5A, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'h5A, 1'b1, 1'b0}},
      '{ROW_CFG,  uirf_pkg::FUNC_TICK, 8'd0,  1'b0, '0},     // zero timeout acts as one
      '{ROW_ITEM, uirf_pkg::FUNC_BYTE, 8'h81, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'h81, 1'b1, 1'b0}},
      '{ROW_ITEM, uirf_pkg::FUNC_BYTE, 8'h3C, 1'b0, '0},
      '{ROW_CFG,  uirf_pkg::FUNC_TICK, 8'd255, 1'b0, '0},    // write while armed
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'h3C, 1'b1, 1'b0}},
      '{ROW_CFG,  uirf_pkg::FUNC_TICK, 8'd2,  1'b0, '0},
      '{ROW_FILL, uirf_pkg::FUNC_BYTE, 8'd64, 1'b0, '0},     // full ring is discarded
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{ROW_FILL, uirf_pkg::FUNC_BYTE, 8'd63, 1'b0, '0},     // largest frame
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b0, '0},
      '{ROW_ITEM, uirf_pkg::FUNC_TICK, 8'h00, 1'b0, '0}
    };

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_ITEM: begin
          send_item(plan[i].func, plan[i].data, plan[i].typed, plan[i].want);
        end
        ROW_CFG: begin
          write_timeout(plan[i].data);
        end
        default: begin
          send_bytes(32'(plan[i].data));
        end
      endcase
    end

    // random phases, each with its own timeout setting
    rand_base = live_items;
    phase     = 0;
    while (phase < MIN_PHASES || live_items - rand_base < RAND_ITEMS) begin
      case (phase)
        0:       write_timeout(uirf_pkg::TIMER_W'(1));
        1:       write_timeout(uirf_pkg::TIMER_W'(0));
        2:       write_timeout(uirf_pkg::TIMER_W'(2));
        default: write_timeout(uirf_pkg::TIMER_W'($urandom_range(0, 4)));
      endcase
      calm   = ($urandom_range(0, 3) == 0);
      eff_to = (idle_ticks == 0) ? 1 : 32'(idle_ticks);
      repeat (SEQ_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // complete frame, sometimes restarted by late bytes
          r = $urandom_range(0, 99);
          k = (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
          send_bytes(k);
          if ($urandom_range(0, 3) == 0) begin
            send_ticks($urandom_range(0, eff_to - 1));
            send_bytes($urandom_range(1, 3));
          end
          send_ticks(eff_to);
          send_ticks($urandom_range(0, 2));
        end else if (r < 85) begin
          // noise
          repeat ($urandom_range(1, 4)) begin
            send_item(uirf_pkg::func_e'($urandom_range(0, 1)),
                      uirf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
          end
        end else begin
          // frame cut short, carried into the next sequence
          send_bytes($urandom_range(1, 5));
          send_ticks($urandom_range(0, eff_to - 1));
        end
      end
      // leave every phase with its frame released
      if (timer_on) begin
        send_ticks(silence_cnt == 0 ? 1 : silence_cnt);
      end
      phase++;
    end

    calm = 1'b0;
    settle();

    $display("covered %0d bytes, %0d live ticks, %0d frames and %0d empty frames over %0d phases",
             byte_cnt, tick_cnt, frame_cnt, empty_cnt, phase);
    $display("%0d timeout writes, %0d results checked, %0d mismatches",
             cfg_writes, checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && frame_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/uirf_pkg.sv
hdl/uirf_in_if.sv
hdl/uirf_out_if.sv
hdl/uart_rx_idle_timeout_framer.sv
hdl/uirf_chk.sv
sim/tb_top.sv
